// ===== sv/bts_pkg.sv =====
package bts_pkg;

	localparam int MAX_BROKERS = 32;
	localparam int MAX_CLIENTS = 256;

	localparam int TABLE_DEPTH = MAX_CLIENTS * MAX_BROKERS;
	localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int BRK_W = (MAX_BROKERS > 1) ? $clog2(MAX_BROKERS) : 1;
	localparam int CLI_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_ID   = 3'd1;
	localparam logic [2:0] ST_BAD_SIZE = 3'd2;
	localparam logic [2:0] ST_DONE     = 3'd3;
	localparam logic [2:0] ST_ORDER    = 3'd4;

	typedef struct packed {
		logic [15:0] client;
		logic [7:0]  broker;
		logic [63:0] batch_no;
		logic [31:0] msg_count;
		logic [31:0] byte_size;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] order_start;
		logic [63:0] byte_pos;
		logic [63:0] broker_batch_number;
	} rsp_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EXEC
	} ctl_state_t;

	typedef struct packed {
		logic clr_en;
		logic load;
		logic rd_en;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
	} sts_t;

endpackage

// ===== sv/bts_ctrl.sv =====
module bts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bts_pkg::sts_t sts,
	output bts_pkg::cmd_t cmd
);
	import bts_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_nxt = S_EXEC;
			end
			S_EXEC: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

endmodule

// ===== sv/bts_dp.sv =====
module bts_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  bts_pkg::cmd_t cmd,
	output bts_pkg::sts_t sts,
	input  bts_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bts_pkg::rsp_t rsp
);
	import bts_pkg::*;

	logic [63:0] tbl_mem [TABLE_DEPTH];
	logic [63:0] off_mem [MAX_BROKERS];
	logic [63:0] bat_mem [MAX_BROKERS];

	req_t              req_q;
	logic [63:0]       exp_q;
	logic [63:0]       off_q;
	logic [63:0]       bat_q;
	logic [63:0]       gcnt_q;
	logic [SLOT_W-1:0] clr_cnt_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic [CLI_W-1:0]  cli_idx;
	logic [BRK_W-1:0]  brk_idx;
	logic [SLOT_W-1:0] slot;
	logic              id_bad;
	logic              size_bad;
	logic              seq_ok;
	logic              ok;
	rsp_t              result;
	logic              tbl_we;
	logic [SLOT_W-1:0] tbl_waddr;
	logic [63:0]       tbl_wdata;
	logic              brk_we;
	logic [BRK_W-1:0]  brk_waddr;
	logic [63:0]       off_wdata;
	logic [63:0]       bat_wdata;
	logic              clr_in_brk;

	assign cli_idx = req_q.client[CLI_W-1:0];
	assign brk_idx = req_q.broker[BRK_W-1:0];
	assign slot = SLOT_W'(SLOT_W'(cli_idx) * SLOT_W'(MAX_BROKERS)) + SLOT_W'(brk_idx);

	assign id_bad = (32'(req_q.broker) >= 32'(MAX_BROKERS))
		|| (32'(req_q.client) >= 32'(MAX_CLIENTS));
	assign size_bad = (req_q.msg_count == 32'd0) || (req_q.byte_size == 32'd0);
	assign seq_ok = (req_q.batch_no == exp_q);
	assign ok = !id_bad && !size_bad && seq_ok;

	always_comb begin
		result = '0;
		if (id_bad) begin
			result.status = ST_BAD_ID;
		end else if (size_bad) begin
			result.status = ST_BAD_SIZE;
		end else if (req_q.batch_no < exp_q) begin
			result.status = ST_DONE;
		end else if (!seq_ok) begin
			result.status = ST_ORDER;
		end else begin
			result.status              = ST_OK;
			result.order_start         = gcnt_q;
			result.byte_pos            = off_q;
			result.broker_batch_number = bat_q;
		end
	end

	assign clr_in_brk = (32'(clr_cnt_q) < 32'(MAX_BROKERS));

	always_comb begin
		tbl_we    = cmd.clr_en || (cmd.commit && ok);
		tbl_waddr = cmd.clr_en ? clr_cnt_q : slot;
		tbl_wdata = cmd.clr_en ? 64'd0 : exp_q + 64'd1;
		brk_we    = (cmd.clr_en && clr_in_brk) || (cmd.commit && ok);
		brk_waddr = cmd.clr_en ? clr_cnt_q[BRK_W-1:0] : brk_idx;
		off_wdata = cmd.clr_en ? 64'd0 : off_q + 64'(req_q.byte_size);
		bat_wdata = cmd.clr_en ? 64'd0 : bat_q + 64'd1;
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		if (cmd.rd_en) begin
			exp_q <= tbl_mem[slot];
		end
	end

	always_ff @(posedge clk) begin
		if (brk_we) begin
			off_mem[brk_waddr] <= off_wdata;
			bat_mem[brk_waddr] <= bat_wdata;
		end
		if (cmd.rd_en) begin
			off_q <= off_mem[brk_idx];
			bat_q <= bat_mem[brk_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.commit) begin
			rsp_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcnt_q      <= 64'd0;
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_en) begin
				clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
			end
			if (cmd.commit && ok) begin
				gcnt_q <= gcnt_q + 64'(req_q.msg_count);
			end
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clr_last = (clr_cnt_q == SLOT_W'(TABLE_DEPTH - 1));
	assign sts.out_free = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== sv/batch_token_sequencer_unit.sv =====
// the result beat is registered in the execute step, after the accept and table read steps
// a new request is accepted only after the last one has passed accept, table read, execute and write back
// the execute cycle waits while a previous result beat is still stalled
// after reset a clearing pass zeroes the expected-sequence table, one entry per cycle,
// over all MAX_CLIENTS * MAX_BROKERS entries (8192), with req_stall held high
module batch_token_sequencer_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bts_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bts_pkg::rsp_t rsp
);
	import bts_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== tb/sv/tb.sv =====
class token_ledger;
	bit [63:0] next_seq [bts_pkg::TABLE_DEPTH];
	bit [63:0] order_pos;
	bit [63:0] brk_offset [bts_pkg::MAX_BROKERS];
	bit [63:0] brk_batch [bts_pkg::MAX_BROKERS];
	bts_pkg::rsp_t due_grants [$];
	int n_status [8];
	int n_logged;
	int n_checked;
	int n_errors;

	function void log_request(bts_pkg::req_t r);
		bts_pkg::rsp_t grant;
		int slot;
		grant = '0;
		slot = int'(r.client) * bts_pkg::MAX_BROKERS + int'(r.broker);
		if (int'(r.broker) >= bts_pkg::MAX_BROKERS ||
				int'(r.client) >= bts_pkg::MAX_CLIENTS) begin
			grant.status = bts_pkg::ST_BAD_ID;
		end else if (r.msg_count == '0 || r.byte_size == '0) begin
			grant.status = bts_pkg::ST_BAD_SIZE;
		end else if (r.batch_no < next_seq[slot]) begin
			grant.status = bts_pkg::ST_DONE;
		end else if (r.batch_no != next_seq[slot]) begin
			grant.status = bts_pkg::ST_ORDER;
		end else begin
			grant.status = bts_pkg::ST_OK;
			grant.order_start = order_pos;
			grant.byte_pos = brk_offset[r.broker];
			grant.broker_batch_number = brk_batch[r.broker];
			order_pos = order_pos + 64'(r.msg_count);
			brk_offset[r.broker] = brk_offset[r.broker] + 64'(r.byte_size);
			brk_batch[r.broker] = brk_batch[r.broker] + 64'd1;
			next_seq[slot] = next_seq[slot] + 64'd1;
		end
		n_status[grant.status]++;
		n_logged++;
		due_grants.push_back(grant);
	endfunction

	function void check_grant(bts_pkg::rsp_t got);
		bts_pkg::rsp_t want;
		n_checked++;
		if (due_grants.size() == 0) begin
			n_errors++;
			if (n_errors <= 10)
				$display("unexpected result beat: status %0d start %h offset %h batch %h",
					got.status, got.order_start, got.byte_pos, got.broker_batch_number);
			return;
		end
		want = due_grants.pop_front();
		if (got.status !== want.status || got.order_start !== want.order_start ||
				got.byte_pos !== want.byte_pos ||
				got.broker_batch_number !== want.broker_batch_number) begin
			n_errors++;
			if (n_errors <= 10) begin
				$display("mismatch on beat %0d: exp status %0d start %h offset %h batch %h",
					n_checked, want.status, want.order_start, want.byte_pos,
					want.broker_batch_number);
				$display("                      got status %0d start %h offset %h batch %h",
					got.status, got.order_start, got.byte_pos, got.broker_batch_number);
			end
		end
	endfunction
endclass

module tb;
	import bts_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int hold_off_req = 0;
	int cycles;
	token_ledger ledger;

	batch_token_sequencer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("** batch_token_sequencer_unit: FAILED **");
		$finish;
	end

	// result side: check accepted beats, then pick next stall
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall)
				ledger.check_grant(rsp);
			if (hold_off_req != 0) begin
				hold_left = hold_off_req;
				hold_off_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
			end
		end
	end

	function automatic bit [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic offer(input req_t r);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		ledger.log_request(r);
	endtask

	task automatic offer_fields(input logic [15:0] client, input logic [7:0] broker,
			input logic [63:0] seq, input logic [31:0] count, input logic [31:0] bytes);
		req_t r;
		r.client = client;
		r.broker = broker;
		r.batch_no = seq;
		r.msg_count = count;
		r.byte_size = bytes;
		offer(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (ledger.due_grants.size() != 0)
			@(posedge clk);
	endtask

	// mostly in-sequence batches on a few hot pairs, the rest stale, ahead or malformed
	function automatic req_t random_request();
		req_t r;
		int pick;
		bit [63:0] due;
		pick = $urandom_range(99);
		r.client = $urandom_range(1) ? 16'($urandom_range(3)) :
			16'($urandom_range(MAX_CLIENTS - 1));
		r.broker = $urandom_range(1) ? 8'($urandom_range(3)) :
			8'($urandom_range(MAX_BROKERS - 1));
		r.msg_count = $urandom_range(1) ? 32'($urandom_range(1, 16)) : $urandom;
		r.byte_size = $urandom_range(1) ? 32'($urandom_range(1, 64)) : $urandom;
		if (r.msg_count == '0)
			r.msg_count = 32'd1;
		if (r.byte_size == '0)
			r.byte_size = 32'd1;
		due = ledger.next_seq[int'(r.client) * MAX_BROKERS + int'(r.broker)];
		r.batch_no = due;
		if (pick < 8) begin
			r.batch_no = (due != '0) ? due - 64'd1 - (rand64() % due) : rand64();
		end else if (pick < 16) begin
			r.batch_no = $urandom_range(1) ? due + 64'($urandom_range(1, 4)) : rand64();
		end else if (pick < 23) begin
			if ($urandom_range(1))
				r.client = 16'($urandom_range(MAX_CLIENTS, 65535));
			else
				r.broker = 8'($urandom_range(MAX_BROKERS, 255));
			r.batch_no = rand64();
		end else if (pick < 30) begin
			case ($urandom_range(2))
				0: r.msg_count = '0;
				1: r.byte_size = '0;
				default: begin
					r.msg_count = '0;
					r.byte_size = '0;
				end
			endcase
		end
		return r;
	endfunction

	task automatic random_run(input int n);
		for (int i = 0; i < n; i++)
			offer(random_request());
	endtask

	initial begin
		ledger = new;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: gate outcomes, id bounds, check priority, per-broker counters
		offer_fields(16'd0, 8'd0, 64'd0, 32'd1, 32'd1);
		offer_fields(16'd0, 8'd0, 64'd0, 32'd1, 32'd1);
		offer_fields(16'd0, 8'd0, 64'd5, 32'd1, 32'd1);
		offer_fields(16'd0, 8'd0, '1, '1, '1);
		offer_fields(16'd0, 8'(MAX_BROKERS), 64'd1, 32'd1, 32'd1);
		offer_fields(16'd0, 8'hff, 64'd1, 32'd1, 32'd1);
		offer_fields(16'(MAX_CLIENTS), 8'd0, 64'd1, 32'd1, 32'd1);
		offer_fields(16'hffff, 8'hff, '1, '0, '0);
		offer_fields(16'd0, 8'd0, 64'd1, 32'd0, 32'd5);
		offer_fields(16'd0, 8'd0, 64'd1, 32'd5, 32'd0);
		offer_fields(16'd0, 8'd0, 64'd0, 32'd0, 32'd0);
		offer_fields(16'(MAX_CLIENTS - 1), 8'(MAX_BROKERS - 1), 64'd0, '1, '1);
		offer_fields(16'(MAX_CLIENTS - 1), 8'(MAX_BROKERS - 1), 64'd1, '1, '1);
		offer_fields(16'(MAX_CLIENTS - 1), 8'(MAX_BROKERS - 1), 64'd0, 32'd1, 32'd1);
		offer_fields(16'(MAX_CLIENTS - 1), 8'(MAX_BROKERS - 1), 64'd3, 32'd1, 32'd1);
		offer_fields(16'd0, 8'd0, 64'd1, '1, 32'd1);
		offer_fields(16'd1, 8'd0, 64'd0, 32'd1, 32'd100);
		offer_fields(16'd0, 8'd0, 64'd2, 32'd1, 32'd1);
		offer_fields(16'd0, 8'd0, 64'd3, 32'd1, 32'd1);
		offer_fields(16'd0, 8'(MAX_BROKERS - 1), 64'd0, 32'd1, 32'd1);
		offer_fields(16'd0, 8'd0, 64'd2, 32'd1, 32'd1);
		drain();

		snd_idle_pct = 16;
		rcv_stall_pct = 85;
		random_run(320);
		drain();

		snd_idle_pct = 85;
		rcv_stall_pct = 16;
		random_run(320);
		drain();

		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		random_run(100);
		// long receiver hold-off while requests keep coming
		hold_off_req = 400;
		random_run(210);
		drain();
		repeat (12) @(posedge clk);

		$display("ran %0d requests, %0d result beats checked, %0d errors",
			ledger.n_logged, ledger.n_checked, ledger.n_errors);
		$display("  ok %0d, bad id %0d, bad size %0d, already processed %0d, out of order %0d",
			ledger.n_status[ST_OK], ledger.n_status[ST_BAD_ID],
			ledger.n_status[ST_BAD_SIZE], ledger.n_status[ST_DONE],
			ledger.n_status[ST_ORDER]);
		if (ledger.n_errors == 0 && ledger.due_grants.size() == 0)
			$display("** batch_token_sequencer_unit: PASSED **");
		else
			$display("** batch_token_sequencer_unit: FAILED **");
		$finish;
	end
endmodule

// ===== files.f =====
sv/bts_pkg.sv
sv/bts_ctrl.sv
sv/bts_dp.sv
sv/batch_token_sequencer_unit.sv
tb/sv/tb.sv
